>>> rtl/nns_pkg.sv
// ============================================================================
// nns_pkg
// Shared types, constants and helpers of the nearest-neighbour scaler.
// ============================================================================
package nns_pkg;

    // fixed field widths
    localparam int COORD_W    = 12;
    localparam int PIXEL_W    = 32;
    localparam int MAP_W      = 6;
    localparam int SRC_CFG_W  = 7;
    localparam int DST_CFG_W  = 12;
    localparam int SIZE_EXT_W = 11;

    // default parameter values
    localparam int SRC_MAX_W_DEF  = 64;
    localparam int SRC_MAX_H_DEF  = 64;
    localparam int COORD_BITS_DEF = 12;

    // register port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

    localparam logic [SRC_CFG_W-1:0] SRC_SIZE_RST = 7'd64;
    localparam logic [DST_CFG_W-1:0] DST_SIZE_RST = 12'd64;

    // action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    typedef struct packed {
        logic               action;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [PIXEL_W-1:0] pixel_in;
    } in_word_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_out;
        logic [MAP_W-1:0]   mapped_x;
        logic [MAP_W-1:0]   mapped_y;
        logic               out_of_range;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_DIV_X,
        ST_MUL_Y,
        ST_DIV_Y,
        ST_READ,
        ST_LOAD
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic mul_x;
        logic div_step;
        logic mul_y;
        logic rd_en;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_write;
        logic in_oor;
        logic div_last;
    } dp_status_t;

    // destination sizes below one act as one
    function automatic logic [DST_CFG_W-1:0] at_least_one(input logic [DST_CFG_W-1:0] v);
        return (v == '0) ? DST_CFG_W'(1) : v;
    endfunction

endpackage

>>> rtl/nns_ram.sv
// ============================================================================
// nns_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module nns_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/nns_datapath.sv
// ============================================================================
// nns_datapath
// Coordinate checks, scale multiply, shared restoring divider, pixel store
// and output word register of the scaler.
// ============================================================================
module nns_datapath #(
    parameter int SRC_MAX_W  = nns_pkg::SRC_MAX_W_DEF,
    parameter int SRC_MAX_H  = nns_pkg::SRC_MAX_H_DEF,
    parameter int COORD_BITS = nns_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  nns_pkg::ctrl_cmd_t               cmd,
    output nns_pkg::dp_status_t              status,
    input  nns_pkg::in_word_t                in_data,
    input  logic [nns_pkg::SRC_CFG_W-1:0]    src_width,
    input  logic [nns_pkg::SRC_CFG_W-1:0]    src_height,
    input  logic [nns_pkg::DST_CFG_W-1:0]    dst_width,
    input  logic [nns_pkg::DST_CFG_W-1:0]    dst_height,
    output nns_pkg::out_word_t               out_data
);

    localparam int CW     = nns_pkg::COORD_W;
    localparam int EW     = nns_pkg::SIZE_EXT_W;
    localparam int XW     = (SRC_MAX_W > 1) ? $clog2(SRC_MAX_W) : 1;
    localparam int YW     = (SRC_MAX_H > 1) ? $clog2(SRC_MAX_H) : 1;
    localparam int SW_W   = $clog2(SRC_MAX_W + 1);
    localparam int SH_W   = $clog2(SRC_MAX_H + 1);
    localparam int QW     = (XW > YW) ? XW : YW;
    localparam int PX_W   = CW + SW_W;
    localparam int PY_W   = CW + SH_W;
    localparam int DIV_W  = (PX_W > PY_W) ? PX_W : PY_W;
    localparam int CNT_W  = (QW > 1) ? $clog2(QW) : 1;
    localparam int DEPTH  = SRC_MAX_W * SRC_MAX_H;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(SRC_MAX_W);
    localparam logic [CW-1:0] COORD_MASK =
        (COORD_BITS >= CW) ? {CW{1'b1}} : CW'((1 << COORD_BITS) - 1);

    // effective sizes
    logic [EW-1:0]                   sw_ext;
    logic [EW-1:0]                   sh_ext;
    logic [SW_W-1:0]                 sw;
    logic [SH_W-1:0]                 sh;
    logic [nns_pkg::DST_CFG_W-1:0]   dw;
    logic [nns_pkg::DST_CFG_W-1:0]   dh;

    logic [CW-1:0]     x_in;
    logic [CW-1:0]     y_in;
    logic              wr_ok;
    logic [ADDR_W-1:0] wr_addr;

    logic [CW-1:0]     x_reg;
    logic [CW-1:0]     y_reg;
    logic              oor_reg;

    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  rem_next;
    logic [DIV_W-1:0]  dsh_reg;
    logic [DIV_W-1:0]  dsh_next;
    logic [QW-1:0]     q_reg;
    logic [QW-1:0]     q_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [XW-1:0]     mx_reg;
    logic [XW-1:0]     mx_next;
    logic [YW-1:0]     my_reg;
    logic [YW-1:0]     my_next;

    logic [PX_W-1:0]   prod_x;
    logic [PY_W-1:0]   prod_y;
    logic              ge;
    logic [XW-1:0]     mx_clamp;
    logic [YW-1:0]     my_clamp;
    logic [ADDR_W-1:0] rd_addr;
    logic [nns_pkg::PIXEL_W-1:0] rd_data;

    nns_pkg::out_word_t out_reg;
    nns_pkg::out_word_t out_next;

    // source sizes: zero acts as one, saturate at the store size
    assign sw_ext = EW'(src_width);
    assign sh_ext = EW'(src_height);
    assign sw = SW_W'((sw_ext == '0) ? EW'(1) :
                      (sw_ext > EW'(SRC_MAX_W)) ? EW'(SRC_MAX_W) : sw_ext);
    assign sh = SH_W'((sh_ext == '0) ? EW'(1) :
                      (sh_ext > EW'(SRC_MAX_H)) ? EW'(SRC_MAX_H) : sh_ext);
    assign dw = nns_pkg::at_least_one(dst_width);
    assign dh = nns_pkg::at_least_one(dst_height);

    // incoming word checks
    assign x_in  = in_data.coord_x & COORD_MASK;
    assign y_in  = in_data.coord_y & COORD_MASK;
    assign wr_ok = (in_data.action == nns_pkg::ACT_WRITE) &&
                   (x_in < CW'(sw)) && (y_in < CW'(sh));
    assign wr_addr = ADDR_W'(y_in[YW-1:0]) * ROW_STRIDE + ADDR_W'(x_in[XW-1:0]);

    assign status.in_write = (in_data.action == nns_pkg::ACT_WRITE);
    assign status.in_oor   = (x_in >= dw) || (y_in >= dh);
    assign status.div_last = (cnt_reg == '0);

    // capture read coordinates
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            x_reg   <= x_in;
            y_reg   <= y_in;
            oor_reg <= status.in_oor;
        end
    end

    // scale products
    assign prod_x = PX_W'(x_reg) * PX_W'(sw);
    assign prod_y = PY_W'(y_reg) * PY_W'(sh);

    // quotient clamps to the last source column / row
    assign mx_clamp = (SW_W'(q_reg[XW-1:0]) >= sw) ? XW'(sw - SW_W'(1)) : q_reg[XW-1:0];
    assign my_clamp = (SH_W'(q_reg[YW-1:0]) >= sh) ? YW'(sh - SH_W'(1)) : q_reg[YW-1:0];

    // restoring divider, one quotient bit a cycle, shared by x and y
    assign ge = (rem_reg >= dsh_reg);

    always_comb
    begin
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        mx_next  = mx_reg;
        my_next  = my_reg;
        if (cmd.mul_x)
        begin
            rem_next = DIV_W'(prod_x);
            dsh_next = DIV_W'(dw) << (XW - 1);
            q_next   = '0;
            cnt_next = CNT_W'(XW - 1);
        end
        else if (cmd.mul_y)
        begin
            rem_next = DIV_W'(prod_y);
            dsh_next = DIV_W'(dh) << (YW - 1);
            q_next   = '0;
            cnt_next = CNT_W'(YW - 1);
            mx_next  = mx_clamp;
        end
        else if (cmd.div_step)
        begin
            rem_next = ge ? (rem_reg - dsh_reg) : rem_reg;
            dsh_next = dsh_reg >> 1;
            q_next   = QW'({q_reg, ge});
            cnt_next = cnt_reg - CNT_W'(1);
        end
        else if (cmd.rd_en)
        begin
            my_next = my_clamp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        mx_reg  <= mx_next;
        my_reg  <= my_next;
    end

    // pixel store
    assign rd_addr = ADDR_W'(my_clamp) * ROW_STRIDE + ADDR_W'(mx_reg);

    nns_ram #(
        .WIDTH (nns_pkg::PIXEL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.accept && wr_ok),
        .wr_addr (wr_addr),
        .wr_data (in_data.pixel_in),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output word register
    always_comb
    begin
        out_next = out_reg;
        if (cmd.load_out)
        begin
            out_next.pixel_out    = oor_reg ? '0 : rd_data;
            out_next.mapped_x     = oor_reg ? '0 : nns_pkg::MAP_W'(mx_reg);
            out_next.mapped_y     = oor_reg ? '0 : nns_pkg::MAP_W'(my_reg);
            out_next.out_of_range = oor_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_data = out_reg;

endmodule

>>> rtl/nns_ctrl.sv
// ============================================================================
// nns_ctrl
// Sequencer of the scaler: input handshake, divider steps, store read and
// output word handshake.
// ============================================================================
module nns_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  nns_pkg::dp_status_t  status,
    output nns_pkg::ctrl_cmd_t   cmd
);

    nns_pkg::state_t state_reg;
    nns_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // state and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nns_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            nns_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.in_write)
                    begin
                        state_next = nns_pkg::ST_IDLE;
                    end
                    else if (status.in_oor)
                    begin
                        state_next = nns_pkg::ST_LOAD;
                    end
                    else
                    begin
                        state_next = nns_pkg::ST_MUL_X;
                    end
                end
            end
            nns_pkg::ST_MUL_X:
            begin
                cmd.mul_x  = 1'b1;
                state_next = nns_pkg::ST_DIV_X;
            end
            nns_pkg::ST_DIV_X:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = nns_pkg::ST_MUL_Y;
                end
            end
            nns_pkg::ST_MUL_Y:
            begin
                cmd.mul_y  = 1'b1;
                state_next = nns_pkg::ST_DIV_Y;
            end
            nns_pkg::ST_DIV_Y:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = nns_pkg::ST_READ;
                end
            end
            nns_pkg::ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = nns_pkg::ST_LOAD;
            end
            nns_pkg::ST_LOAD:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = nns_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nns_pkg::ST_IDLE;
            end
        endcase
    end

    // output word handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign in_stall  = (state_reg != nns_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> rtl/nearest_neighbor_scaler.sv
// ============================================================================
// nearest_neighbor_scaler
// Source pixel store answering reads of a nearest-neighbour scaled image.
// ============================================================================
// Input words (in_valid / in_stall / in_data) carry an action. A write stores
// pixel_in at source (coord_x, coord_y) and gives no output word; writes
// outside the source size are dropped. A read maps a destination coordinate
// to the source by x*src_width/dst_width and y*src_height/dst_height and
// returns one output word (out_valid / out_stall / out_data) with the stored
// colour and the chosen source column and row. A read outside the
// destination size returns out_of_range with zero fields, without the
// divider steps. An in-range read steps through ST_MUL_X, ST_DIV_X,
// ST_MUL_Y, ST_DIV_Y, ST_READ and ST_LOAD: the shared restoring divider
// gives one quotient bit a cycle for each axis, then the store read is
// registered. One read is in flight at a time, so no further word is taken
// until its output word is loaded; writes are taken one per cycle while the
// block is idle. The output register holds a finished word while the
// receiver stalls; the next item is taken meanwhile, and a further result
// waits until it drains. Sizes are to be set over the APB port while idle;
// the block itself does not enforce it. Reset sets all sizes to 64 and
// empties the output; the pixel store is not cleared.
// ============================================================================
module nearest_neighbor_scaler #(
    parameter int SRC_MAX_W  = nns_pkg::SRC_MAX_W_DEF,
    parameter int SRC_MAX_H  = nns_pkg::SRC_MAX_H_DEF,
    parameter int COORD_BITS = nns_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input words
    input  logic                              in_valid,
    output logic                              in_stall,
    input  nns_pkg::in_word_t                 in_data,
    // output words
    output logic                              out_valid,
    input  logic                              out_stall,
    output nns_pkg::out_word_t                out_data,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nns_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [nns_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [nns_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    logic [nns_pkg::SRC_CFG_W-1:0] src_width_reg;
    logic [nns_pkg::SRC_CFG_W-1:0] src_height_reg;
    logic [nns_pkg::DST_CFG_W-1:0] dst_width_reg;
    logic [nns_pkg::DST_CFG_W-1:0] dst_height_reg;
    logic [nns_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          reg_wr;

    nns_pkg::ctrl_cmd_t  cmd;
    nns_pkg::dp_status_t status;

    assign pready  = 1'b1;
    assign reg_idx = paddr[nns_pkg::APB_ADDR_W-1:2];
    assign reg_wr  = psel && penable && pwrite;

    // size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= nns_pkg::SRC_SIZE_RST;
            src_height_reg <= nns_pkg::SRC_SIZE_RST;
            dst_width_reg  <= nns_pkg::DST_SIZE_RST;
            dst_height_reg <= nns_pkg::DST_SIZE_RST;
        end
        else if (reg_wr)
        begin
            case (reg_idx)
                nns_pkg::REG_SRC_WIDTH:  src_width_reg  <= pwdata[nns_pkg::SRC_CFG_W-1:0];
                nns_pkg::REG_SRC_HEIGHT: src_height_reg <= pwdata[nns_pkg::SRC_CFG_W-1:0];
                nns_pkg::REG_DST_WIDTH:  dst_width_reg  <= pwdata[nns_pkg::DST_CFG_W-1:0];
                nns_pkg::REG_DST_HEIGHT: dst_height_reg <= pwdata[nns_pkg::DST_CFG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (reg_idx)
            nns_pkg::REG_SRC_WIDTH:  prdata = nns_pkg::APB_DATA_W'(src_width_reg);
            nns_pkg::REG_SRC_HEIGHT: prdata = nns_pkg::APB_DATA_W'(src_height_reg);
            nns_pkg::REG_DST_WIDTH:  prdata = nns_pkg::APB_DATA_W'(dst_width_reg);
            nns_pkg::REG_DST_HEIGHT: prdata = nns_pkg::APB_DATA_W'(dst_height_reg);
            default:                 prdata = '0;
        endcase
    end

    // sequencer
    nns_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath and pixel store
    nns_datapath #(
        .SRC_MAX_W  (SRC_MAX_W),
        .SRC_MAX_H  (SRC_MAX_H),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_data    (in_data),
        .src_width  (src_width_reg),
        .src_height (src_height_reg),
        .dst_width  (dst_width_reg),
        .dst_height (dst_height_reg),
        .out_data   (out_data)
    );

endmodule

>>> verif/nearest_neighbor_scaler_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// nearest_neighbor_scaler_tb
// Self-checking bench for the nearest-neighbour scaler. Pixel writes and
// scaled reads are driven through the valid/stall input, and every output
// word is checked against a local predictor of the store and the scale
// mapping. A fixed table of corner words runs first, at the reset sizes.
// Then a series of size settings follows, extremes among them, each with
// random words. Reads are only issued once their source pixel holds data.
// ============================================================================
module nearest_neighbor_scaler_tb;
    import nns_pkg::*;

    localparam int STORE_W      = SRC_MAX_W_DEF;
    localparam int STORE_H      = SRC_MAX_H_DEF;
    localparam int STORE_DEPTH  = STORE_W * STORE_H;
    localparam int COORD_MAX    = (1 << COORD_W) - 1;
    localparam int DRAIN_CYCLES = 32;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_WORDS = 600;
    localparam int N_PLANNED    = 8;
    localparam int N_DRAWN      = 3;
    localparam int N_PROBES     = 19;

    typedef struct packed {
        logic [SRC_CFG_W-1:0] sw;
        logic [SRC_CFG_W-1:0] sh;
        logic [DST_CFG_W-1:0] dw;
        logic [DST_CFG_W-1:0] dh;
    } size_set_t;

    typedef struct packed {
        in_word_t  word;
        logic      typed;
        out_word_t answer;
    } probe_t;

    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_word_t              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_word_t             out_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor state: source image, which pixels hold data, current sizes
    logic [PIXEL_W-1:0]   source_image [STORE_DEPTH];
    bit                   pixel_written [STORE_DEPTH];
    logic [SRC_CFG_W-1:0] cfg_sw = SRC_SIZE_RST;
    logic [SRC_CFG_W-1:0] cfg_sh = SRC_SIZE_RST;
    logic [DST_CFG_W-1:0] cfg_dw = DST_SIZE_RST;
    logic [DST_CFG_W-1:0] cfg_dh = DST_SIZE_RST;

    out_word_t read_answers [$];

    int mismatches    = 0;
    int words_taken   = 0;
    int reads_taken   = 0;
    int results_seen  = 0;
    int settings_done = 0;
    int calm_left     = 0;
    int stall_left    = 0;

    // corner words at the reset sizes (identity scale 64 x 64)
    probe_t probes [N_PROBES] = '{
        '{'{ACT_WRITE, 12'd0,    12'd0,    32'hFFFF_FFFF}, 1'b0, '0},
        '{'{ACT_WRITE, 12'd63,   12'd63,   32'h0000_0000}, 1'b0, '0},
        '{'{ACT_WRITE, 12'd63,   12'd0,    32'hA5A5_5A5A}, 1'b0, '0},
        '{'{ACT_WRITE, 12'd0,    12'd63,   32'h5A5A_A5A5}, 1'b0, '0},
        '{'{ACT_WRITE, 12'd64,   12'd0,    32'hDEAD_BEEF}, 1'b0, '0},
        '{'{ACT_WRITE, 12'd0,    12'd64,   32'h1234_5678}, 1'b0, '0},
        '{'{ACT_WRITE, 12'd4095, 12'd4095, 32'hFFFF_FFFF}, 1'b0, '0},
        '{'{ACT_READ,  12'd0,    12'd0,    32'hFFFF_FFFF}, 1'b1,
          '{32'hFFFF_FFFF, 6'd0, 6'd0, 1'b0}},
        '{'{ACT_READ,  12'd63,   12'd63,   32'h0000_0000}, 1'b1,
          '{32'h0000_0000, 6'd63, 6'd63, 1'b0}},
        '{'{ACT_READ,  12'd63,   12'd0,    32'h0000_0000}, 1'b1,
          '{32'hA5A5_5A5A, 6'd63, 6'd0, 1'b0}},
        '{'{ACT_READ,  12'd0,    12'd63,   32'h0000_0000}, 1'b1,
          '{32'h5A5A_A5A5, 6'd0, 6'd63, 1'b0}},
        '{'{ACT_READ,  12'd64,   12'd0,    32'h0000_0000}, 1'b1,
          '{32'h0, 6'd0, 6'd0, 1'b1}},
        '{'{ACT_READ,  12'd0,    12'd64,   32'h0000_0000}, 1'b1,
          '{32'h0, 6'd0, 6'd0, 1'b1}},
        '{'{ACT_READ,  12'd4095, 12'd4095, 32'hFFFF_FFFF}, 1'b1,
          '{32'h0, 6'd0, 6'd0, 1'b1}},
        '{'{ACT_READ,  12'd4095, 12'd0,    32'h0000_0000}, 1'b1,
          '{32'h0, 6'd0, 6'd0, 1'b1}},
        '{'{ACT_WRITE, 12'd0,    12'd0,    32'h0000_0001}, 1'b0, '0},
        '{'{ACT_READ,  12'd0,    12'd0,    32'h0000_0000}, 1'b1,
          '{32'h0000_0001, 6'd0, 6'd0, 1'b0}},
        '{'{ACT_WRITE, 12'd31,   12'd17,   32'h8000_0000}, 1'b0, '0},
        '{'{ACT_READ,  12'd31,   12'd17,   32'h0000_0000}, 1'b1,
          '{32'h8000_0000, 6'd31, 6'd17, 1'b0}}
    };

    // size settings: upscale to the maximum, unit, zero, saturated, mixed
    size_set_t size_plan [N_PLANNED] = '{
        '{7'd64,  7'd64,  12'd4095, 12'd4095},
        '{7'd1,   7'd1,   12'd1,    12'd1},
        '{7'd0,   7'd0,   12'd0,    12'd0},
        '{7'd127, 7'd127, 12'd17,   12'd9},
        '{7'd37,  7'd5,   12'd100,  12'd3000},
        '{7'd64,  7'd64,  12'd1,    12'd1},
        '{7'd3,   7'd64,  12'd4095, 12'd0},
        '{7'd65,  7'd2,   12'd64,   12'd63}
    };

    nearest_neighbor_scaler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    // source size as used: zero acts as one, above the store saturates
    function automatic int unsigned used_src(input logic [SRC_CFG_W-1:0] v,
                                             input int unsigned lim);
        if (v == '0)
            return 1;
        if (v > lim)
            return lim;
        return v;
    endfunction

    function automatic int unsigned used_dst(input logic [DST_CFG_W-1:0] v);
        return (v == '0) ? 1 : v;
    endfunction

    // store index that a read maps to, or -1 when outside the destination
    function automatic int mapped_index(input logic [COORD_W-1:0] x, y);
        int unsigned sw, sh, dw, dh, mx, my;
        sw = used_src(cfg_sw, STORE_W);
        sh = used_src(cfg_sh, STORE_H);
        dw = used_dst(cfg_dw);
        dh = used_dst(cfg_dh);
        if (x >= dw || y >= dh)
            return -1;
        mx = (x * sw) / dw;
        my = (y * sh) / dh;
        if (mx >= sw)
            mx = sw - 1;
        if (my >= sh)
            my = sh - 1;
        return int'(my * STORE_W + mx);
    endfunction

    // expected output word for a read at the current sizes
    function automatic out_word_t scaled_lookup(input logic [COORD_W-1:0] x, y);
        out_word_t r;
        int idx;
        r = '0;
        idx = mapped_index(x, y);
        if (idx < 0)
        begin
            r.out_of_range = 1'b1;
        end
        else
        begin
            r.pixel_out = source_image[idx];
            r.mapped_x  = MAP_W'(idx % STORE_W);
            r.mapped_y  = MAP_W'(idx / STORE_W);
        end
        return r;
    endfunction

    function automatic in_word_t make_word(input logic act, input int unsigned x, y,
                                           input logic [PIXEL_W-1:0] pix);
        in_word_t w;
        w.action   = act;
        w.coord_x  = COORD_W'(x);
        w.coord_y  = COORD_W'(y);
        w.pixel_in = pix;
        return w;
    endfunction

    function automatic logic [PIXEL_W-1:0] random_colour();
        int unsigned r;
        r = $urandom_range(15);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom();
    endfunction

    // sender idle cycles: mostly none or short, a few long, calm stretches
    function automatic int pick_gap();
        int unsigned r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 3)
            calm_left = $urandom_range(40, 10);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 96)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // drive one input word and update the predictor once it is taken
    task automatic send_word(input in_word_t w, input logic typed, input out_word_t answer);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (in_stall);
        words_taken++;
        if (w.action == ACT_WRITE)
        begin
            if (w.coord_x < used_src(cfg_sw, STORE_W) && w.coord_y < used_src(cfg_sh, STORE_H))
            begin
                source_image[w.coord_y * STORE_W + w.coord_x]  = w.pixel_in;
                pixel_written[w.coord_y * STORE_W + w.coord_x] = 1'b1;
            end
        end
        else
        begin
            reads_taken++;
            read_answers.push_back(typed ? answer : scaled_lookup(w.coord_x, w.coord_y));
        end
    endtask

    // a read whose source pixel is still empty gets a write to it first
    task automatic send_read(input int unsigned x, y);
        int idx;
        idx = mapped_index(COORD_W'(x), COORD_W'(y));
        if (idx >= 0 && !pixel_written[idx])
            send_word(make_word(ACT_WRITE, idx % STORE_W, idx / STORE_W, random_colour()),
                      1'b0, '0);
        send_word(make_word(ACT_READ, x, y, random_colour()), 1'b0, '0);
    endtask

    task automatic send_random_word();
        int unsigned pick, x, y;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            x = $urandom_range(used_dst(cfg_dw) - 1);
            y = $urandom_range(used_dst(cfg_dh) - 1);
            if ($urandom_range(9) == 0)
            begin
                x = $urandom_range(COORD_MAX);
                y = $urandom_range(COORD_MAX);
            end
            send_read(x, y);
        end
        else if (pick < 88)
        begin
            x = $urandom_range(used_src(cfg_sw, STORE_W) - 1);
            y = $urandom_range(used_src(cfg_sh, STORE_H) - 1);
            send_word(make_word(ACT_WRITE, x, y, random_colour()), 1'b0, '0);
        end
        else
        begin
            // stray write, mostly outside the source
            x = $urandom_range(COORD_MAX);
            y = $urandom_range(COORD_MAX);
            send_word(make_word(ACT_WRITE, x, y, random_colour()), 1'b0, '0);
        end
    endtask

    // corners of each setting: first and last pixel, just outside each edge
    task automatic probe_corners();
        int unsigned dw, dh;
        dw = used_dst(cfg_dw);
        dh = used_dst(cfg_dh);
        send_read(0, 0);
        send_read(dw - 1, dh - 1);
        send_read(dw, 0);
        send_read(0, dh);
        send_word(make_word(ACT_WRITE, used_src(cfg_sw, STORE_W), 0, random_colour()),
                  1'b0, '0);
        send_word(make_word(ACT_WRITE, 0, used_src(cfg_sh, STORE_H), random_colour()),
                  1'b0, '0);
    endtask

    // register write then read back, then psel drops
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== value)
            note_mismatch($sformatf("register %0d wrote %0h read back %0h", idx, value, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // new sizes only once the block has drained
    task automatic apply_sizes(input size_set_t s);
        in_valid <= 1'b0;
        while (read_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(REG_SRC_WIDTH, APB_DATA_W'(s.sw));
        cfg_sw = s.sw;
        write_reg(REG_SRC_HEIGHT, APB_DATA_W'(s.sh));
        cfg_sh = s.sh;
        write_reg(REG_DST_WIDTH, APB_DATA_W'(s.dw));
        cfg_dw = s.dw;
        write_reg(REG_DST_HEIGHT, APB_DATA_W'(s.dh));
        cfg_dh = s.dh;
        settings_done++;
    endtask

    // receiver stall: short and long holds, and long stretches without any
    always @(posedge clk)
    begin : stall_gen
        int unsigned r;
        if (!rst_n)
        begin
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
        end
        else
        begin
            r = $urandom_range(99);
            if (r < 40)
            begin
                out_stall  <= 1'b0;
                stall_left = $urandom_range(6, 1);
            end
            else if (r < 48)
            begin
                out_stall  <= 1'b0;
                stall_left = $urandom_range(200, 40);
            end
            else if (r < 88)
            begin
                out_stall  <= 1'b1;
                stall_left = $urandom_range(3, 1);
            end
            else if (r < 96)
            begin
                out_stall  <= 1'b1;
                stall_left = $urandom_range(12, 4);
            end
            else
            begin
                out_stall  <= 1'b1;
                stall_left = $urandom_range(60, 20);
            end
        end
    end

    // compare each taken output word with the oldest expected answer
    always @(posedge clk)
    begin : result_check
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (read_answers.size() == 0)
            begin
                note_mismatch($sformatf("unexpected word pixel %h x %0d y %0d oor %b",
                                        out_data.pixel_out, out_data.mapped_x,
                                        out_data.mapped_y, out_data.out_of_range));
            end
            else
            begin
                want = read_answers.pop_front();
                if (out_data.pixel_out !== want.pixel_out || out_data.mapped_x !== want.mapped_x
                    || out_data.mapped_y !== want.mapped_y
                    || out_data.out_of_range !== want.out_of_range)
                    note_mismatch($sformatf(
                        "expected pixel %h x %0d y %0d oor %b, got pixel %h x %0d y %0d oor %b",
                        want.pixel_out, want.mapped_x, want.mapped_y, want.out_of_range,
                        out_data.pixel_out, out_data.mapped_x, out_data.mapped_y,
                        out_data.out_of_range));
            end
        end
    end

    initial
    begin : stimulus
        size_set_t s;
        int per_setting;
        per_setting = RANDOM_WORDS / (N_PLANNED + N_DRAWN);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner words at the reset sizes
        for (int i = 0; i < N_PROBES; i++)
            send_word(probes[i].word, probes[i].typed, probes[i].answer);

        // planned settings, then drawn ones with a bias towards small destinations
        for (int p = 0; p < N_PLANNED + N_DRAWN; p++)
        begin
            if (p < N_PLANNED)
            begin
                s = size_plan[p];
            end
            else
            begin
                s.sw = SRC_CFG_W'($urandom_range(127));
                s.sh = SRC_CFG_W'($urandom_range(127));
                s.dw = DST_CFG_W'($urandom_range(1) ? $urandom_range(128) : $urandom_range(4095));
                s.dh = DST_CFG_W'($urandom_range(1) ? $urandom_range(128) : $urandom_range(4095));
            end
            apply_sizes(s);
            probe_corners();
            for (int i = 0; i < per_setting; i++)
                send_random_word();
        end
        in_valid <= 1'b0;

        while (read_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("run covered %0d input words (%0d reads) and %0d checked results",
                 words_taken, reads_taken, results_seen);
        $display("over %0d size settings incl. zero, saturated and 4095 sizes", settings_done);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hard limit on run time
    initial
    begin : watchdog
        #10_000_000;
        $display("timeout with %0d answers outstanding", read_answers.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
